/* sv/bqbc_pkg.sv */
package bqbc_pkg;

	// Stack geometry
	localparam int STACK_DEPTH = 64;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int KIND_W      = 3;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [CNT_W-1:0]  count_t;

	// Open kind codes held on the stack
	localparam kind_t KIND_PAREN  = 3'd0;
	localparam kind_t KIND_SQUARE = 3'd1;
	localparam kind_t KIND_CURLY  = 3'd2;
	localparam kind_t KIND_ANGLE  = 3'd3;
	localparam kind_t KIND_SQUOTE = 3'd4;
	localparam kind_t KIND_DQUOTE = 3'd5;
	localparam kind_t KIND_NONE   = 3'd7;

	// Error kinds, as reported on the verdict
	typedef enum logic [1:0] {
		ERR_NONE        = 2'd0,
		ERR_CLOSE       = 2'd1,
		ERR_OPEN_AT_END = 2'd2,
		ERR_OVERFLOW    = 2'd3
	} err_t;

	// Byte class
	typedef struct packed {
		logic  is_quote;
		logic  is_open;
		logic  is_close;
		kind_t kind;
	} sym_class_t;

	// Operation broadcast to every stack cell
	typedef struct packed {
		logic push;
		logic pop;
	} stk_op_t;

	function automatic sym_class_t classify(input logic [7:0] b);
		sym_class_t c;
		c = '{is_quote: 1'b0, is_open: 1'b0, is_close: 1'b0, kind: KIND_NONE};
		case (b)
			8'h28: begin c.is_open  = 1'b1; c.kind = KIND_PAREN;  end // (
			8'h5B: begin c.is_open  = 1'b1; c.kind = KIND_SQUARE; end // [
			8'h7B: begin c.is_open  = 1'b1; c.kind = KIND_CURLY;  end // {
			8'h3C: begin c.is_open  = 1'b1; c.kind = KIND_ANGLE;  end // <
			8'h29: begin c.is_close = 1'b1; c.kind = KIND_PAREN;  end // )
			8'h5D: begin c.is_close = 1'b1; c.kind = KIND_SQUARE; end // ]
			8'h7D: begin c.is_close = 1'b1; c.kind = KIND_CURLY;  end // }
			8'h3E: begin c.is_close = 1'b1; c.kind = KIND_ANGLE;  end // >
			8'h27: begin c.is_quote = 1'b1; c.kind = KIND_SQUOTE; end // '
			8'h22: begin c.is_quote = 1'b1; c.kind = KIND_DQUOTE; end // "
			default: ;
		endcase
		return c;
	endfunction

endpackage

/* sv/bqbc_sym_if.sv */
interface bqbc_sym_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       last_symbol;

	modport source (output valid, output symbol, output last_symbol, input ready);
	modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

/* sv/bqbc_verdict_if.sv */
interface bqbc_verdict_if;
	logic       valid;
	logic       ready;
	logic       balanced;
	logic [1:0] error_kind;

	modport source (output valid, output balanced, output error_kind, input ready);
	modport sink   (input valid, input balanced, input error_kind, output ready);
endinterface

/* sv/bqbc_cell.sv */
module bqbc_cell
	import bqbc_pkg::*;
(
	input  logic    clk,
	input  stk_op_t op,
	input  kind_t   from_above,
	input  kind_t   from_below,
	output kind_t   kind
);

	kind_t kind_q;

	// Push shifts the stack down one cell, pop shifts it up
	always_ff @(posedge clk) begin
		if (op.push) begin
			kind_q <= from_above;
		end else if (op.pop) begin
			kind_q <= from_below;
		end
	end

	assign kind = kind_q;

endmodule

/* sv/bracket_quote_balance_checker.sv */
// Channel   Dir   Handshake      Payload
// symbols   in    valid/ready    symbol[7:0], last_symbol
// verdict   out   valid/ready    balanced, error_kind[1:0]
//
// One byte per cycle: each transfer does at most one push or pop on a shift-register
// stack whose top is always cell 0, so the match test is one cell read.
// The verdict is registered and valid in the cycle after the final byte's transfer.
// Reset clears the count, the error latch and the output valid; cell contents
// are not cleared. symbols stalls only while a verdict waits untaken.
module bracket_quote_balance_checker
	import bqbc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	bqbc_sym_if.sink        symbols,
	bqbc_verdict_if.source  verdict
);

	count_t     count_q;
	err_t       err_q;
	logic       out_valid_q;
	logic       out_balanced_q;
	err_t       out_kind_q;

	kind_t      cell_kind [STACK_DEPTH];
	stk_op_t    op;
	kind_t      push_kind;
	sym_class_t cls;
	logic       take;
	logic       top_match;
	logic       full;
	count_t     count_nx;
	err_t       err_nx;
	err_t       kind_nx;

	assign symbols.ready = !out_valid_q || verdict.ready;
	assign take          = symbols.valid && symbols.ready;

	// Decode the byte against the top of stack
	always_comb begin
		cls       = classify(symbols.symbol);
		top_match = (count_q != '0) && (cell_kind[0] == cls.kind);
		full      = (count_q == CNT_W'(STACK_DEPTH));
		push_kind = cls.kind;
		op        = '{push: 1'b0, pop: 1'b0};
		count_nx  = count_q;
		err_nx    = err_q;
		if (take && err_q == ERR_NONE) begin
			if ((cls.is_quote || cls.is_close) && top_match) begin
				op.pop   = 1'b1;
				count_nx = count_q - 1'b1;
			end else if (cls.is_quote || cls.is_open) begin
				if (full) begin
					err_nx = ERR_OVERFLOW;
				end else begin
					op.push  = 1'b1;
					count_nx = count_q + 1'b1;
				end
			end else if (cls.is_close) begin
				err_nx = ERR_CLOSE;
			end
		end
		if (err_nx != ERR_NONE) begin
			kind_nx = err_nx;
		end else if (count_nx != '0) begin
			kind_nx = ERR_OPEN_AT_END;
		end else begin
			kind_nx = ERR_NONE;
		end
	end

	// Row of stack cells
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		kind_t above;
		kind_t below;
		if (i == 0) begin : g_top
			assign above = push_kind;
		end else begin : g_mid
			assign above = cell_kind[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign below = KIND_NONE;
		end else begin : g_up
			assign below = cell_kind[i+1];
		end
		bqbc_cell u_cell (
			.clk        (clk),
			.op         (op),
			.from_above (above),
			.from_below (below),
			.kind       (cell_kind[i])
		);
	end

	// Count and error latch; a final byte clears both
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= ERR_NONE;
		end else if (take) begin
			if (symbols.last_symbol) begin
				count_q <= '0;
				err_q   <= ERR_NONE;
			end else begin
				count_q <= count_nx;
				err_q   <= err_nx;
			end
		end
	end

	// Verdict output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && symbols.last_symbol) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && symbols.last_symbol) begin
			out_balanced_q <= (kind_nx == ERR_NONE);
			out_kind_q     <= kind_nx;
		end
	end

	assign verdict.valid      = out_valid_q;
	assign verdict.balanced   = out_balanced_q;
	assign verdict.error_kind = out_kind_q;

endmodule
